### sv/positional_insert_remove_list_defines.svh
// assertion macros for the positional list block
`ifndef POSITIONAL_INSERT_REMOVE_LIST_DEFINES_SVH
`define POSITIONAL_INSERT_REMOVE_LIST_DEFINES_SVH

// same-cycle implication, idle during reset
`define PIRL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle during reset
`define PIRL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pirl_pkg.sv
package pirl_pkg;

    // default sizes
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed port field widths
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int CNT_W = 5;

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // shift command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } cmd_t;

endpackage

### sv/pirl_cell.sv
module pirl_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 5,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  pirl_pkg::cmd_t        cmd,
    input  logic [CW-1:0]         at,
    input  logic [CW-1:0]         count,
    input  logic [DATA_WIDTH-1:0] ins_value,
    input  logic [DATA_WIDTH-1:0] left_value,
    input  logic [DATA_WIDTH-1:0] right_value,
    output logic [DATA_WIDTH-1:0] value,
    output logic                  tail
);

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic [DATA_WIDTH-1:0] value_reg;
    logic [DATA_WIDTH-1:0] value_next;

    // pick own word, the new word, or a neighbor's word
    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins)
        begin
            if (IDX == at)
                value_next = ins_value;
            else if (IDX > at && IDX <= count)
                value_next = left_value;
        end
        else if (cmd.rem)
        begin
            if (IDX >= at && (IDX + 1'b1) < count)
                value_next = right_value;
        end
    end

    // entry storage, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // this cell holds the back entry
    assign tail  = (count != '0) && (IDX == count - 1'b1);
    assign value = value_reg;

endmodule

### sv/positional_insert_remove_list.sv
// positional insert/remove list built as a chain of shifting cells
// done follows the accepted start through the busy and done registers
// busy is high in the cycle after accept, and no new word is taken while it is high
// the cells shift at the accepting edge; the back entry is then selected and registered while busy
// reset clears the count and control only; entries stay undefined, no clearing pass
`include "positional_insert_remove_list_defines.svh"

module positional_insert_remove_list #(
    parameter int DEPTH      = pirl_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = pirl_pkg::DATA_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       func,
    input  logic [pirl_pkg::POS_W-1:0] position,
    input  logic [pirl_pkg::VAL_W-1:0] value,
    output logic                       done,
    output logic [pirl_pkg::VAL_W-1:0] front_value,
    output logic [pirl_pkg::VAL_W-1:0] back_value,
    output logic [pirl_pkg::CNT_W-1:0] entry_count,
    output logic                       is_empty,
    output logic                       insert_dropped,
    output logic                       remove_idle
);

    import pirl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  busy_reg;
    logic                  done_reg;
    logic                  dropped_reg;
    logic                  dropped_next;
    logic                  idle_reg;
    logic                  idle_next;
    logic [VAL_W-1:0]      front_reg;
    logic [VAL_W-1:0]      back_reg;
    logic [CNT_W-1:0]      cnt_out_reg;
    logic                  empty_out_reg;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic [PW-1:0]         pos_w;
    logic [PW-1:0]         cnt_w;
    logic [CW-1:0]         at;
    cmd_t                  cmd;
    logic [DATA_WIDTH-1:0] ins_value;
    logic [DATA_WIDTH-1:0] back_sel;

    logic [DATA_WIDTH-1:0] cell_q  [DEPTH];
    logic [DATA_WIDTH-1:0] left_w  [DEPTH];
    logic [DATA_WIDTH-1:0] right_w [DEPTH];
    logic [DEPTH-1:0]      tail_w;

    assign ins_value = DATA_WIDTH'(value);

    // decode the word into a shift command, target slot, status flags and next count
    always_comb
    begin
        pos_w        = PW'(position);
        cnt_w        = PW'(count_reg);
        full         = (count_reg == CW'(DEPTH));
        empty        = (count_reg == '0);
        accept       = start && !busy_reg;
        cmd.ins      = accept && (func == FUNC_INSERT) && !full;
        cmd.rem      = accept && (func == FUNC_REMOVE) && !empty;
        dropped_next = accept && (func == FUNC_INSERT) && full;
        idle_next    = accept && (func == FUNC_REMOVE) && empty;
        if (func == FUNC_INSERT)
        begin
            if (pos_w >= cnt_w)
                at = count_reg;
            else
                at = CW'(position);
        end
        else
        begin
            if (count_reg < CW'(2) || position == '0)
                at = '0;
            else if (pos_w >= cnt_w)
                at = count_reg - 1'b1;
            else
                at = CW'(position);
        end
        count_next = count_reg;
        if (cmd.ins)
            count_next = count_reg + 1'b1;
        else if (cmd.rem)
            count_next = count_reg - 1'b1;
    end

    // chain of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign left_w[i] = '0;
        end
        else
        begin : g_mid_l
            assign left_w[i] = cell_q[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_w[i] = '0;
        end
        else
        begin : g_mid_r
            assign right_w[i] = cell_q[i+1];
        end

        pirl_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CW         (CW),
            .INDEX      (i)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .at          (at),
            .count       (count_reg),
            .ins_value   (ins_value),
            .left_value  (left_w[i]),
            .right_value (right_w[i]),
            .value       (cell_q[i]),
            .tail        (tail_w[i])
        );
    end

    // one-hot select of the back entry
    always_comb
    begin
        back_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (tail_w[i])
                back_sel = back_sel | cell_q[i];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            dropped_reg <= 1'b0;
            idle_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= accept;
            done_reg  <= busy_reg;
            if (accept)
            begin
                dropped_reg <= dropped_next;
                idle_reg    <= idle_next;
            end
        end
    end

    // result word capture
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            front_reg     <= empty ? '0 : VAL_W'(cell_q[0]);
            back_reg      <= VAL_W'(back_sel);
            cnt_out_reg   <= CNT_W'(count_reg);
            empty_out_reg <= empty;
        end
    end

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign front_value    = front_reg;
    assign back_value     = back_reg;
    assign entry_count    = cnt_out_reg;
    assign is_empty       = empty_out_reg;
    assign insert_dropped = dropped_reg;
    assign remove_idle    = idle_reg;

    // checks
    `PIRL_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH),
        "count beyond depth")
    `PIRL_ASSERT_NEXT(a_ins_grows, cmd.ins, count_reg == $past(count_reg) + 1'b1,
        "insert did not grow count")
    `PIRL_ASSERT_NEXT(a_rem_shrinks, cmd.rem, count_reg == $past(count_reg) - 1'b1,
        "remove did not shrink count")
    `PIRL_ASSERT_NEXT(a_done_follows, busy_reg, done_reg && !busy_reg,
        "done did not follow busy")
    `PIRL_ASSERT_NOW(a_flags_excl, done_reg, !(insert_dropped && remove_idle),
        "both status flags set")

endmodule

### sim/tb_positional_insert_remove_list.sv
`default_nettype none

module tb_positional_insert_remove_list;

    timeunit 1ns;
    timeprecision 1ps;

    import pirl_pkg::*;

    localparam int LIST_DEPTH     = DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int REPORT_LIMIT   = 10;

    // status reported after every word
    typedef struct packed {
        logic [VAL_W-1:0] front;
        logic [VAL_W-1:0] back;
        logic [CNT_W-1:0] count;
        logic             empty;
        logic             dropped;
        logic             idle;
    } list_status_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             func;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
    logic             done;
    logic [VAL_W-1:0] front_value;
    logic [VAL_W-1:0] back_value;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;
    logic             insert_dropped;
    logic             remove_idle;

    // shadow copy of the list contents, front at index 0
    logic [VAL_W-1:0] shadow_list[$];
    list_status_t     pending_status[$];
    int               fail_count = 0;
    int               stall_cycles = 0;
    bit               gaps_enabled = 1'b1;

    positional_insert_remove_list uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .position       (position),
        .value          (value),
        .done           (done),
        .front_value    (front_value),
        .back_value     (back_value),
        .entry_count    (entry_count),
        .is_empty       (is_empty),
        .insert_dropped (insert_dropped),
        .remove_idle    (remove_idle)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // apply one word to the shadow list and return the status it should report
    function automatic list_status_t apply_to_shadow(input logic f, input logic [POS_W-1:0] p,
                                                     input logic [VAL_W-1:0] v);
        list_status_t st;
        int           held;
        int           at;
        st = '0;
        held = shadow_list.size();
        if (f == FUNC_INSERT)
        begin
            if (held >= LIST_DEPTH)
                st.dropped = 1'b1;
            else
            begin
                // insert at or past the end is a push
                at = (p >= held) ? held : p;
                shadow_list.insert(at, v);
            end
        end
        else
        begin
            if (held == 0)
                st.idle = 1'b1;
            else if (held < 2 || p == 0)
                shadow_list.delete(0);
            else
            begin
                // remove past the end saturates to the back entry
                at = (p >= held) ? held - 1 : p;
                shadow_list.delete(at);
            end
        end
        held = shadow_list.size();
        if (held != 0)
        begin
            st.front = shadow_list[0];
            st.back  = shadow_list[held-1];
        end
        st.count = CNT_W'(held);
        st.empty = (held == 0);
        return st;
    endfunction

    // drive one word, hold it until accepted, then record the expected status
    task automatic send_word(input logic f, input logic [POS_W-1:0] p,
                             input logic [VAL_W-1:0] v);
        int gap;
        gap = 0;
        if (gaps_enabled && $urandom_range(99) < 22)
            gap = $urandom_range(1, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        func     <= f;
        position <= p;
        value    <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_status.push_back(apply_to_shadow(f, p, v));
    endtask

    // position biased toward the live part of the list
    function automatic logic [POS_W-1:0] pick_position();
        int r;
        int top;
        r = $urandom_range(99);
        top = shadow_list.size() + 1;
        if (top > 31)
            top = 31;
        if (r < 70)
            return POS_W'($urandom_range(0, top));
        else if (r < 85)
            return '0;
        else
            return POS_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        else if (r < 20)
            return '1;
        else
            return $urandom;
    endfunction

    // empty list corners: remove on empty, push into empty, pop of a single entry
    task automatic test_empty_edges();
        send_word(FUNC_REMOVE, 5'd5, 32'h1234_5678);
        send_word(FUNC_INSERT, 5'd0, 32'h0000_0000);
        send_word(FUNC_REMOVE, 5'd3, 32'hFFFF_FFFF);
        send_word(FUNC_INSERT, 5'd31, 32'hFFFF_FFFF);
    endtask

    // fill to full through front, middle and back inserts, then one refused insert
    task automatic test_fill_to_full();
        logic [POS_W-1:0] p;
        int               k;
        k = 0;
        while (shadow_list.size() < LIST_DEPTH)
        begin
            case (k % 5)
                0: p = '0;
                1: p = 5'd1;
                2: p = POS_W'(shadow_list.size());
                3: p = 5'd31;
                default: p = POS_W'($urandom_range(0, shadow_list.size()));
            endcase
            send_word(FUNC_INSERT, p, (k % 2) ? 32'hAAAA_AAAA ^ k : 32'h5555_5555 ^ k);
            k++;
        end
        send_word(FUNC_INSERT, 5'd4, 32'hDEAD_BEEF);
    endtask

    // remove past the end, at the front, in the middle and exactly at the count
    task automatic test_remove_positions();
        send_word(FUNC_REMOVE, 5'd31, '0);
        send_word(FUNC_REMOVE, 5'd0, '1);
        send_word(FUNC_REMOVE, 5'd7, '0);
        send_word(FUNC_REMOVE, POS_W'(shadow_list.size()), '0);
    endtask

    // random words with a given share of inserts
    task automatic run_random(input int n, input int insert_pct);
        logic f;
        for (int i = 0; i < n; i++)
        begin
            f = ($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
            send_word(f, pick_position(), pick_value());
        end
    endtask

    task automatic test_random_walk();
        run_random(500, 50);
    endtask

    // repeated fill and drain so full and empty are reached often
    task automatic test_fill_drain_cycles();
        for (int i = 0; i < 5; i++)
        begin
            run_random(40, 80);
            run_random(40, 20);
        end
    endtask

    // back-to-back words, no sender gaps
    task automatic test_back_to_back();
        gaps_enabled = 1'b0;
        run_random(300, 55);
        gaps_enabled = 1'b1;
    endtask

    // mostly inserts, list sits near full and refuses inserts
    task automatic test_near_full();
        run_random(350, 70);
    endtask

    // result checker
    always @(posedge clk)
    begin
        list_status_t got;
        list_status_t want;
        if (rst_n && done)
        begin
            got = '{front_value, back_value, entry_count, is_empty, insert_dropped,
                    remove_idle};
            if (pending_status.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result: front=%h back=%h count=%0d", got.front,
                             got.back, got.count);
            end
            else
            begin
                want = pending_status.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("mismatch: exp front=%h back=%h count=%0d empty=%b drop=%b idle=%b",
                                 want.front, want.back, want.count, want.empty,
                                 want.dropped, want.idle);
                        $display("          got front=%h back=%h count=%0d empty=%b drop=%b idle=%b",
                                 got.front, got.back, got.count, got.empty,
                                 got.dropped, got.idle);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word accepted and no result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        func     = FUNC_INSERT;
        position = '0;
        value    = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_edges();
        test_fill_to_full();
        test_remove_positions();
        test_random_walk();
        test_fill_drain_cycles();
        test_back_to_back();
        test_near_full();

        @(negedge clk);
        start <= 1'b0;

        // drain outstanding results, then allow for the block latency
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        fail_count += pending_status.size();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
